// ----- rtl/adc_sample_averager_with_retry_defines.svh -----
// Assertion macros for the ADC sample averager.
// Included by the top level; no other dependencies.
`ifndef ADC_SAMPLE_AVERAGER_WITH_RETRY_DEFINES_SVH
`define ADC_SAMPLE_AVERAGER_WITH_RETRY_DEFINES_SVH

`ifndef SYNTH
`define ASWR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define ASWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define ASWR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASWR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/aswr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ADC sample averager.
// No dependencies.
package aswr_pkg;

    localparam int SampleW   = 12;
    localparam int SumW      = 16;
    localparam int CntW      = 5;
    localparam int AttW      = 8;
    localparam int GainW     = 12;
    localparam int MvW       = 14;
    localparam int FracBits  = 10;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 12;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [AttW-1:0]  MaxAttemptsRst = 8'd64;
    localparam logic [CntW-1:0]  TargetCountRst = 5'd8;
    localparam logic [GainW-1:0] GainQ10Rst     = 12'd1894;

    localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TARGET_COUNT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_Q10     = 2'd2;

    typedef struct packed {
        logic               reading_present;
        logic [SampleW-1:0] reading_mv;
    } t_in_item;

    typedef struct packed {
        logic [MvW-1:0]  battery_mv;
        logic            success;
        logic [CntW-1:0] valid_used;
        logic [AttW-1:0] attempts_used;
    } t_out_item;

endpackage

// ----- rtl/adc_sample_averager_with_retry.sv -----
`timescale 1ns / 1ps
// ADC sample averager with retry: accumulation, iterative scale and divide.
// Depends on aswr_pkg and adc_sample_averager_with_retry_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one read
//   attempt per transaction. Output channel (o_out_valid / i_out_stall /
//   o_out_data) carries one measurement result. Configuration writes go
//   through i_cfg_valid / o_cfg_ready with a register index and data;
//   o_cfg_ready is always high and unknown indexes are dropped.
// Sequencing:
//   An attempt that does not end a measurement is taken in S_IDLE; the next
//   attempt may follow at once. An attempt that ends a measurement with at
//   least one valid reading passes through acceptance, the 16x12 gain multiply
//   (S_MUL), the 18 steps of the shared restoring divider (one quotient bit per
//   cycle, S_DIV) and the output register load (S_DONE) before the next one is
//   taken. A measurement with no valid reading goes straight to S_DONE.
// Reset: synchronous, active low; clears counters, output valid and loads
//   the register defaults (64 attempts, 8 readings, gain 1894).
// Stall: the output register holds its result while i_out_stall is high;
//   accumulation goes on, but the next finished measurement waits in the
//   sequencer and the input channel stalls until the register frees up.
`include "adc_sample_averager_with_retry_defines.svh"

module adc_sample_averager_with_retry #(
    parameter int SAMPLE_BITS = aswr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  aswr_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output aswr_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aswr_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [aswr_pkg::CfgDataW-1:0]     i_cfg_data
);
    import aswr_pkg::*;

    localparam int ProdW  = SumW + GainW;
    localparam int QuoW   = ProdW - FracBits;
    localparam int StepW  = $clog2(QuoW);
    localparam logic [StepW-1:0] LastStep = StepW'(QuoW - 1);
    localparam logic [SampleW-1:0] SampleMask = (SAMPLE_BITS >= SampleW) ?
        {SampleW{1'b1}} : SampleW'((1 << SAMPLE_BITS) - 1);
    localparam logic [QuoW-1:0] MvMax = QuoW'({MvW{1'b1}});

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} t_state;

    t_state             r_state;
    logic [AttW-1:0]    r_max_att;
    logic [CntW-1:0]    r_target;
    logic [GainW-1:0]   r_gain;
    logic [SumW-1:0]    r_sum;
    logic [CntW-1:0]    r_valid_cnt;
    logic [AttW-1:0]    r_att_cnt;

    logic [SumW-1:0]    r_w_sum;
    logic [CntW-1:0]    r_w_cnt;
    logic [AttW-1:0]    r_w_att;
    logic [QuoW-1:0]    r_dvd;
    logic [CntW-1:0]    r_rem;
    logic [StepW-1:0]   r_step;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_load;
    logic [SampleW-1:0] w_sample;
    logic               w_good;
    logic [SumW:0]      w_sum_ext;
    logic [SumW-1:0]    n_sum;
    logic [CntW-1:0]    n_valid_cnt;
    logic [AttW-1:0]    n_att_cnt;
    logic               w_finish;
    logic [ProdW-1:0]   w_prod;
    logic [CntW:0]      w_trial;
    logic               w_ge;
    logic [CntW:0]      w_diff;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_DONE) && w_out_free;

    // accumulate one attempt, saturating the sum
    always_comb begin
        w_sample    = i_in_data.reading_mv & SampleMask;
        w_good      = i_in_data.reading_present && (w_sample != '0);
        w_sum_ext   = {1'b0, r_sum} + (SumW + 1)'(w_sample);
        n_att_cnt   = r_att_cnt + AttW'(1);
        n_valid_cnt = r_valid_cnt;
        n_sum       = r_sum;
        if (w_good) begin
            n_valid_cnt = r_valid_cnt + CntW'(1);
            n_sum       = w_sum_ext[SumW] ? {SumW{1'b1}} : w_sum_ext[SumW-1:0];
        end
        w_finish = (n_valid_cnt >= r_target) || (n_att_cnt >= r_max_att);
    end

    // shared datapath: gain multiply, then one restoring divide step a cycle
    assign w_prod  = ProdW'(r_w_sum) * ProdW'(r_gain);
    assign w_trial = {r_rem, r_dvd[QuoW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_w_cnt});
    assign w_diff  = w_trial - {1'b0, r_w_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_att   <= MaxAttemptsRst;
            r_target    <= TargetCountRst;
            r_gain      <= GainQ10Rst;
            r_sum       <= '0;
            r_valid_cnt <= '0;
            r_att_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_ATTEMPTS: r_max_att <= i_cfg_data[AttW-1:0];
                    CFG_TARGET_COUNT: r_target  <= i_cfg_data[CntW-1:0];
                    CFG_GAIN_Q10:     r_gain    <= i_cfg_data[GainW-1:0];
                    default: ;
                endcase
            end

            // load a new result, else drop the one just taken
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_finish) begin
                            r_w_sum     <= n_sum;
                            r_w_cnt     <= n_valid_cnt;
                            r_w_att     <= n_att_cnt;
                            r_sum       <= '0;
                            r_valid_cnt <= '0;
                            r_att_cnt   <= '0;
                            r_state     <= (n_valid_cnt != '0) ? S_MUL : S_DONE;
                        end else begin
                            r_sum       <= n_sum;
                            r_valid_cnt <= n_valid_cnt;
                            r_att_cnt   <= n_att_cnt;
                        end
                    end
                end
                S_MUL: begin
                    // drop the Q10 fraction: floor(p/(c*1024)) == floor(floor(p/1024)/c)
                    r_dvd   <= w_prod[ProdW-1:FracBits];
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dvd  <= {r_dvd[QuoW-2:0], w_ge};
                    r_rem  <= w_ge ? w_diff[CntW-1:0] : w_trial[CntW-1:0];
                    r_step <= r_step + StepW'(1);
                    if (r_step == LastStep) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.attempts_used <= r_w_att;
                        r_out.valid_used    <= r_w_cnt;
                        if (r_w_cnt != '0) begin
                            r_out.success    <= 1'b1;
                            r_out.battery_mv <= (r_dvd > MvMax) ? {MvW{1'b1}} : r_dvd[MvW-1:0];
                        end else begin
                            r_out.success    <= 1'b0;
                            r_out.battery_mv <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASWR_ASSERT_IMPLIES(a_fail_is_zero, i_clk, i_rst_n, r_out_valid && !r_out.success, (r_out.battery_mv == '0) && (r_out.valid_used == '0))
    `ASWR_ASSERT_IMPLIES(a_success_has_count, i_clk, i_rst_n, r_out_valid && r_out.success, r_out.valid_used != '0)
    `ASWR_ASSERT_NEXT(a_attempt_advance, i_clk, i_rst_n, w_in_acc, (r_att_cnt == '0) || (r_att_cnt == $past(r_att_cnt) + AttW'(1)))
    `ASWR_ASSERT_NEXT(a_divide_ends, i_clk, i_rst_n, (r_state == S_DIV) && (r_step == LastStep), r_state == S_DONE)

endmodule

// ----- tb/tb_adc_sample_averager_with_retry.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for adc_sample_averager_with_retry: random and directed read
// attempts, register writes between phases, a scoreboard class that predicts each result.
// Depends on aswr_pkg and the RTL of the block only.
module tb_adc_sample_averager_with_retry;
    import aswr_pkg::*;

    localparam int  NumPhases     = 10;
    localparam int  AttemptsPhase = 110;
    localparam int  SettleCycles  = 40;
    localparam int  CycleLimit    = 1000000;
    localparam int  HoldOffCycles = 400;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    bit quiet;
    int hold_req;
    int cycles;
    int in_stall_cycles;

    adc_sample_averager_with_retry u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    class measurement_scoreboard;
        logic [AttW-1:0]  max_attempts;
        logic [CntW-1:0]  target_count;
        logic [GainW-1:0] gain_q10;
        logic [SumW-1:0]  run_sum;
        logic [CntW-1:0]  valid_cnt;
        logic [AttW-1:0]  attempt_cnt;
        t_out_item        pending_q[$];
        int mismatches;
        int averaged;
        int rejected;
        int attempts;
        int sum_clips;

        function new();
            max_attempts = MaxAttemptsRst;
            target_count = TargetCountRst;
            gain_q10     = GainQ10Rst;
            run_sum      = '0;
            valid_cnt    = '0;
            attempt_cnt  = '0;
        endfunction

        function void apply_setting(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_MAX_ATTEMPTS: max_attempts = data[AttW-1:0];
                CFG_TARGET_COUNT: target_count = data[CntW-1:0];
                CFG_GAIN_Q10:     gain_q10 = data[GainW-1:0];
                default: ;
            endcase
        endfunction

        // Accumulate one attempt; queue the measurement it closes, if any.
        function void note_attempt(t_in_item it);
            logic [SumW:0]   wide;
            logic [63:0]     num;
            logic [63:0]     den;
            logic [63:0]     quo;
            t_out_item       res;
            attempts++;
            attempt_cnt = attempt_cnt + 1'b1;
            if (it.reading_present && it.reading_mv != '0) begin
                wide = {1'b0, run_sum} + it.reading_mv;
                if (wide[SumW]) begin
                    run_sum = '1;
                    sum_clips++;
                end else begin
                    run_sum = wide[SumW-1:0];
                end
                valid_cnt = valid_cnt + 1'b1;
            end
            if (valid_cnt >= target_count || attempt_cnt >= max_attempts) begin
                res = '0;
                if (valid_cnt != '0) begin
                    num = 64'(run_sum) * 64'(gain_q10);
                    den = 64'(valid_cnt) << FracBits;
                    quo = num / den;
                    if (quo > 64'((1 << MvW) - 1)) quo = 64'((1 << MvW) - 1);
                    res.battery_mv = quo[MvW-1:0];
                    res.success    = 1'b1;
                    res.valid_used = valid_cnt;
                end
                res.attempts_used = attempt_cnt;
                pending_q.push_back(res);
                run_sum     = '0;
                valid_cnt   = '0;
                attempt_cnt = '0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            bit        bad;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result mv=%0d ok=%0b valid=%0d att=%0d", $realtime,
                             got.battery_mv, got.success, got.valid_used, got.attempts_used);
                return;
            end
            want = pending_q.pop_front();
            if (want.success) averaged++;
            else rejected++;
            bad = (got.battery_mv !== want.battery_mv) || (got.success !== want.success) ||
                  (got.valid_used !== want.valid_used) ||
                  (got.attempts_used !== want.attempts_used);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: mismatch exp mv=%0d ok=%0b valid=%0d att=%0d,", $realtime,
                           want.battery_mv, want.success, want.valid_used, want.attempts_used);
                    $display(" got mv=%0d ok=%0b valid=%0d att=%0d", got.battery_mv,
                             got.success, got.valid_used, got.attempts_used);
                end
            end
        endfunction
    endclass

    measurement_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check accepted results, count cycles, stop on the limit.
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        if (i_in_valid && o_in_stall) in_stall_cycles++;
        if (cycles >= CycleLimit) begin
            $display("run limit of %0d cycles reached", CycleLimit);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item random_attempt(bit high);
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        it.reading_present = ($urandom_range(0, 99) < 85);
        if (high) it.reading_mv = SampleW'($urandom_range(3800, 4095));
        else if (r < 8) it.reading_mv = '0;
        else if (r < 16) it.reading_mv = '1;
        else if (r < 30) it.reading_mv = SampleW'($urandom_range(1, 15));
        else it.reading_mv = SampleW'($urandom_range(1, 4095));
        return it;
    endfunction

    // Offer one attempt after a random gap; return at the falling edge after acceptance.
    task automatic offer_attempt(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_attempt(it);
        @(negedge i_clk);
    endtask

    task automatic offer_reading(input logic present, input logic [SampleW-1:0] mv);
        t_in_item it;
        it.reading_present = present;
        it.reading_mv      = mv;
        offer_attempt(it);
    endtask

    task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_setting(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop valid, drain all outstanding results, then wait SettleCycles more falling edges.
    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold-off on request.
    initial begin : rx
        int stall_left;
        int hold_left;
        int r;
        i_out_stall = 1'b0;
        stall_left  = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
                if (!quiet && r < 20) stall_left = $urandom_range(1, 3);
                else if (!quiet && r < 24) stall_left = $urandom_range(10, 50);
            end
        end
    end

    initial begin : main
        int phase;
        int n;
        bit high;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        quiet       = 1'b0;
        hold_req    = 0;
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: rejects first, then eight good readings close the measurement.
        offer_reading(1'b0, 12'hFFF);
        offer_reading(1'b1, 12'h000);
        offer_reading(1'b1, 12'hFFF);
        offer_reading(1'b1, 12'h001);
        offer_reading(1'b1, 12'h800);
        offer_reading(1'b1, 12'd1365);
        offer_reading(1'b1, 12'hFFF);
        offer_reading(1'b1, 12'd7);
        offer_reading(1'b1, 12'd3000);
        offer_reading(1'b1, 12'd100);
        settle();
        // Zero attempt limit: every attempt ends a measurement.
        write_setting(CFG_MAX_ATTEMPTS, 12'd0);
        offer_reading(1'b0, 12'h000);
        offer_reading(1'b1, 12'hFFF);
        settle();
        // Zero target.
        write_setting(CFG_MAX_ATTEMPTS, 12'd255);
        write_setting(CFG_TARGET_COUNT, 12'd0);
        offer_reading(1'b1, 12'd5);
        offer_reading(1'b0, 12'd5);
        settle();
        // Gain extremes.
        write_setting(CFG_TARGET_COUNT, 12'd1);
        write_setting(CFG_GAIN_Q10, 12'hFFF);
        offer_reading(1'b1, 12'hFFF);
        settle();
        write_setting(CFG_GAIN_Q10, 12'd0);
        offer_reading(1'b1, 12'hFFF);
        settle();
        // Retries run out with no valid reading.
        write_setting(CFG_TARGET_COUNT, 12'd2);
        write_setting(CFG_MAX_ATTEMPTS, 12'd3);
        write_setting(CFG_GAIN_Q10, 12'd1894);
        offer_reading(1'b0, 12'd1);
        offer_reading(1'b1, 12'd0);
        offer_reading(1'b0, 12'hFFF);
        settle();
        // Unknown index is ignored; attempts run out with one valid reading.
        write_setting(CFG_UNUSED, 12'hFFF);
        write_setting(CFG_MAX_ATTEMPTS, 12'd2);
        write_setting(CFG_TARGET_COUNT, 12'd16);
        offer_reading(1'b1, 12'd10);
        offer_reading(1'b0, 12'd0);

        for (phase = 0; phase < NumPhases; phase++) begin
            settle();
            quiet = (phase % 4 == 1);
            high  = 1'b0;
            case (phase)
                0: begin
                    // Large target with high readings: the sum clips.
                    write_setting(CFG_MAX_ATTEMPTS, 12'd255);
                    write_setting(CFG_TARGET_COUNT, 12'd31);
                    write_setting(CFG_GAIN_Q10, 12'hFFF);
                    high = 1'b1;
                end
                1: begin
                    write_setting(CFG_MAX_ATTEMPTS, 12'd1);
                    write_setting(CFG_TARGET_COUNT, 12'd16);
                    write_setting(CFG_GAIN_Q10, 12'($urandom));
                end
                2: begin
                    // Every valid reading finishes a measurement; hold the output off so the input backs up.
                    write_setting(CFG_MAX_ATTEMPTS, 12'd255);
                    write_setting(CFG_TARGET_COUNT, 12'd1);
                    write_setting(CFG_GAIN_Q10, 12'd1894);
                    hold_req = HoldOffCycles;
                end
                3: begin
                    write_setting(CFG_MAX_ATTEMPTS, 12'd0);
                    write_setting(CFG_TARGET_COUNT, 12'd0);
                    write_setting(CFG_GAIN_Q10, 12'($urandom));
                end
                4: begin
                    write_setting(CFG_MAX_ATTEMPTS, 12'($urandom));
                    write_setting(CFG_TARGET_COUNT, 12'd16);
                    write_setting(CFG_GAIN_Q10, 12'd0);
                end
                default: begin
                    write_setting(CFG_MAX_ATTEMPTS, 12'($urandom_range(1, 40)));
                    write_setting(CFG_TARGET_COUNT, 12'($urandom_range(1, 16)));
                    write_setting(CFG_GAIN_Q10, 12'($urandom));
                    if ($urandom_range(0, 2) == 0) write_setting(CFG_UNUSED, 12'($urandom));
                end
            endcase
            for (n = 0; n < AttemptsPhase; n++) offer_attempt(random_attempt(high));
        end
        quiet = 1'b0;
        settle();

        $display("Checked %0d measurements (%0d averaged, %0d rejected) from %0d read attempts.",
                 sb.averaged + sb.rejected, sb.averaged, sb.rejected, sb.attempts);
        $display("Running sum clipped %0d times; input held off %0d cycles by back-pressure.",
                 sb.sum_clips, in_stall_cycles);
        if (sb.pending_q.size() != 0)
            $display("%0d expected measurements never arrived", sb.pending_q.size());
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
